// File: rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg - source code tokenizer package
// Shared types, codes and constant tables of the tokenizer.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int CHAR_BITS_DEF     = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int TAB_BITS          = 5;
  localparam int MAX_RESULTS       = 4;
  localparam logic [TAB_BITS-1:0] TAB_WIDTH_RST = 5'd4;

  localparam logic [1:0] EV_TOKEN = 2'd0;
  localparam logic [1:0] EV_LEX   = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [2:0] ERR_UNEXPECTED = 3'd0;
  localparam logic [2:0] ERR_NUMBER     = 3'd1;
  localparam logic [2:0] ERR_COMMENT    = 3'd2;
  localparam logic [2:0] ERR_ESCAPE     = 3'd3;
  localparam logic [2:0] ERR_QUOTE      = 3'd4;

  localparam logic [5:0] K_WORD     = 6'd0;
  localparam logic [5:0] K_INT      = 6'd1;
  localparam logic [5:0] K_HEX      = 6'd2;
  localparam logic [5:0] K_FLOAT    = 6'd3;
  localparam logic [5:0] K_STRING   = 6'd4;
  localparam logic [5:0] K_END      = 6'd5;
  localparam logic [5:0] K_NONE     = 6'd0;
  localparam logic [5:0] K_DOT      = 6'd24;
  localparam logic [5:0] K_DIV_EQ   = 6'd25;
  localparam logic [5:0] K_DIV      = 6'd26;
  localparam logic [5:0] K_SHL_EQ   = 6'd29;
  localparam logic [5:0] K_SHL      = 6'd30;
  localparam logic [5:0] K_SHR_EQ   = 6'd35;
  localparam logic [5:0] K_SHR      = 6'd36;

  typedef enum logic [21:0] {
    M_IDLE  = 22'h000001,
    M_WORD  = 22'h000002,
    M_OP    = 22'h000004,
    M_OP2   = 22'h000008,
    M_SLASH = 22'h000010,
    M_DOT   = 22'h000020,
    M_BLOCK = 22'h000040,
    M_BSTAR = 22'h000080,
    M_LINE  = 22'h000100,
    M_ZERO  = 22'h000200,
    M_HEX0  = 22'h000400,
    M_HEX   = 22'h000800,
    M_DEC   = 22'h001000,
    M_ZDIG  = 22'h002000,
    M_FRAC  = 22'h004000,
    M_EXP   = 22'h008000,
    M_ESIGN = 22'h010000,
    M_EDIG  = 22'h020000,
    M_STR   = 22'h040000,
    M_ESC   = 22'h080000,
    M_XESC0 = 22'h100000,
    M_XESC  = 22'h200000
  } mode_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [5:0] token_kind;
    logic [2:0] error_code;
  } ev_ctrl_t;

  // k2 of zero continues to the M_OP2 shift state
  typedef struct packed {
    logic       hit;
    logic [7:0] c1;
    logic [5:0] k1;
    logic [7:0] c2;
    logic [5:0] k2;
    logic [5:0] dflt;
  } op_rule_t;

  function automatic op_rule_t op_lookup(input logic [7:0] lead);
    op_rule_t r;
    r = '0;
    unique case (lead)
      8'h21:   r = '{1'b1, 8'h3d, 6'd6,  8'h00, 6'd0,  6'd7};
      8'h25:   r = '{1'b1, 8'h3d, 6'd8,  8'h00, 6'd0,  6'd9};
      8'h26:   r = '{1'b1, 8'h3d, 6'd10, 8'h26, 6'd11, 6'd12};
      8'h2a:   r = '{1'b1, 8'h3d, 6'd15, 8'h00, 6'd0,  6'd16};
      8'h2b:   r = '{1'b1, 8'h3d, 6'd17, 8'h2b, 6'd18, 6'd19};
      8'h2d:   r = '{1'b1, 8'h3d, 6'd21, 8'h2d, 6'd22, 6'd23};
      8'h3c:   r = '{1'b1, 8'h3d, 6'd31, 8'h3c, 6'd0,  6'd32};
      8'h3d:   r = '{1'b1, 8'h3d, 6'd33, 8'h00, 6'd0,  6'd34};
      8'h3e:   r = '{1'b1, 8'h3d, 6'd37, 8'h3e, 6'd0,  6'd38};
      8'h5e:   r = '{1'b1, 8'h3d, 6'd42, 8'h00, 6'd0,  6'd43};
      8'h7c:   r = '{1'b1, 8'h3d, 6'd45, 8'h7c, 6'd46, 6'd47};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h28:   k = 6'd13;
      8'h29:   k = 6'd14;
      8'h2c:   k = 6'd20;
      8'h3a:   k = 6'd27;
      8'h3b:   k = 6'd28;
      8'h3f:   k = 6'd39;
      8'h5b:   k = 6'd40;
      8'h5d:   k = 6'd41;
      8'h7b:   k = 6'd44;
      8'h7d:   k = 6'd48;
      8'h7e:   k = 6'd49;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/scl_in_if.sv
// ----------------------------------------------------------------------------
// scl_in_if - character input channel
// Valid/ready channel carrying one source character per transaction.
// ----------------------------------------------------------------------------
interface scl_in_if #(
  parameter int CHAR_BITS = scl_pkg::CHAR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

// File: rtl/scl_out_if.sv
// ----------------------------------------------------------------------------
// scl_out_if - tokenizer event channel
// Valid/ready channel carrying one token, lexeme or error event per transaction.
// ----------------------------------------------------------------------------
interface scl_out_if #(
  parameter int CHAR_BITS     = scl_pkg::CHAR_BITS_DEF,
  parameter int POSITION_BITS = scl_pkg::POSITION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               event_kind;
  logic [5:0]               token_kind;
  logic [2:0]               error_code;
  logic [CHAR_BITS-1:0]     lexeme_char;
  logic [POSITION_BITS-1:0] first_line;
  logic [POSITION_BITS-1:0] last_line;
  logic [POSITION_BITS-1:0] first_col;
  logic [POSITION_BITS-1:0] last_col;
  logic                     last_of_run;

  modport source (output valid, event_kind, token_kind, error_code, lexeme_char,
                  first_line, last_line, first_col, last_col, last_of_run,
                  input ready);
  modport sink   (input valid, event_kind, token_kind, error_code, lexeme_char,
                  first_line, last_line, first_col, last_col, last_of_run,
                  output ready);
endinterface

// File: rtl/source_code_tokenizer.sv
// ----------------------------------------------------------------------------
// source_code_tokenizer - streaming C-style tokenizer
// Takes one source character per transaction, returns token, lexeme and
// error events with line and column positions.
// ----------------------------------------------------------------------------
// While the event channel is ready, a character that causes at most one event
// is taken every cycle, and the result buffer hands out one event per cycle.
// A character that causes n events (n up to 4) holds the input until the
// buffer has handed them all out; the next character is taken in the cycle
// the last event of the previous one leaves. Characters that cause no event
// are taken back to back. Write tab_width only while no events are pending.
module source_code_tokenizer #(
  parameter int CHAR_BITS     = scl_pkg::CHAR_BITS_DEF,
  parameter int POSITION_BITS = scl_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  scl_in_if.sink                       in_ch,
  scl_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [scl_pkg::TAB_BITS-1:0] cfg_wdata
);

  logic [scl_pkg::TAB_BITS-1:0] tab_width_r;
  logic                         step;
  logic                         load_ok;
  scl_pkg::ev_ctrl_t            res_ctl [scl_pkg::MAX_RESULTS];
  logic [CHAR_BITS-1:0]         res_ch  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0]     res_fl  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0]     res_ll  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0]     res_fc  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0]     res_lc  [scl_pkg::MAX_RESULTS];
  logic [2:0]                   res_cnt;

  assign in_ch.ready = load_ok;
  assign step        = in_ch.valid && load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= scl_pkg::TAB_WIDTH_RST;
    end else if (cfg_we) begin
      tab_width_r <= cfg_wdata;
    end
  end

  scl_core #(
    .CHAR_BITS     (CHAR_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .char_code   (in_ch.char_code),
    .end_of_text (in_ch.end_of_text),
    .tab_width   (tab_width_r),
    .res_ctl     (res_ctl),
    .res_ch      (res_ch),
    .res_fl      (res_fl),
    .res_ll      (res_ll),
    .res_fc      (res_fc),
    .res_lc      (res_lc),
    .res_cnt     (res_cnt)
  );

  scl_out_buf #(
    .CHAR_BITS     (CHAR_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step),
    .res_ctl (res_ctl),
    .res_ch  (res_ch),
    .res_fl  (res_fl),
    .res_ll  (res_ll),
    .res_fc  (res_fc),
    .res_lc  (res_lc),
    .res_cnt (res_cnt),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/scl_core.sv
// ----------------------------------------------------------------------------
// scl_core - tokenizer scan state and step logic
// Holds the scan state and computes the events of one character.
// ----------------------------------------------------------------------------
module scl_core #(
  parameter int CHAR_BITS     = scl_pkg::CHAR_BITS_DEF,
  parameter int POSITION_BITS = scl_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [CHAR_BITS-1:0]          char_code,
  input  logic                          end_of_text,
  input  logic [scl_pkg::TAB_BITS-1:0]  tab_width,
  output scl_pkg::ev_ctrl_t             res_ctl [scl_pkg::MAX_RESULTS],
  output logic [CHAR_BITS-1:0]          res_ch  [scl_pkg::MAX_RESULTS],
  output logic [POSITION_BITS-1:0]      res_fl  [scl_pkg::MAX_RESULTS],
  output logic [POSITION_BITS-1:0]      res_ll  [scl_pkg::MAX_RESULTS],
  output logic [POSITION_BITS-1:0]      res_fc  [scl_pkg::MAX_RESULTS],
  output logic [POSITION_BITS-1:0]      res_lc  [scl_pkg::MAX_RESULTS],
  output logic [2:0]                    res_cnt
);

  localparam int CB = CHAR_BITS;
  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};
  localparam logic [PB-1:0] PONE = PB'(1);

  typedef struct packed {
    scl_pkg::mode_t mode;
    logic [PB-1:0]  line;
    logic [PB-1:0]  col;
    logic [PB-1:0]  sl;
    logic [PB-1:0]  sc;
    logic [7:0]     held;
    logic [CB-1:0]  esc;
  } st_t;

  typedef struct packed {
    logic              v;
    scl_pkg::ev_ctrl_t ctl;
    logic [CB-1:0]     ch;
    logic [PB-1:0]     fl;
    logic [PB-1:0]     ll;
    logic [PB-1:0]     fc;
    logic [PB-1:0]     lc;
  } rec_t;

  typedef struct packed {
    st_t  s;
    logic done;
    rec_t e0;
    rec_t e1;
  } pass_t;

  st_t st_r, st_nxt;

  function automatic logic [CB-1:0] cc(input logic [7:0] x);
    return CB'(x);
  endfunction

  function automatic logic in_rng(input logic [CB-1:0] c, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (c >= cc(lo)) && (c <= cc(hi));
  endfunction

  function automatic logic is_digit(input logic [CB-1:0] c);
    return in_rng(c, 8'h30, 8'h39);
  endfunction

  function automatic logic is_hex(input logic [CB-1:0] c);
    return is_digit(c) || in_rng(c, 8'h41, 8'h46) || in_rng(c, 8'h61, 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [CB-1:0] c);
    return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic is_space(input logic [CB-1:0] c);
    return (c == cc(8'h20)) || in_rng(c, 8'h09, 8'h0d);
  endfunction

  function automatic logic is_word(input logic [CB-1:0] c);
    logic p;
    p = in_rng(c, 8'h21, 8'h2f) || in_rng(c, 8'h3a, 8'h40) ||
        in_rng(c, 8'h5b, 8'h5e) || in_rng(c, 8'h7b, 8'h7e);
    return (in_rng(c, 8'h21, 8'h7e) && !p) || (c >= cc(8'h80));
  endfunction

  function automatic st_t adv(input st_t s, input logic [CB-1:0] c,
                              input logic [scl_pkg::TAB_BITS-1:0] tw);
    st_t       r;
    logic [PB:0] sum;
    r   = s;
    sum = {1'b0, s.col} + (PB+1)'(tw);
    if (c == cc(8'h0a)) begin
      if (s.line != PMAX) r.line = s.line + PONE;
      r.col = PONE;
    end else if (c == cc(8'h09)) begin
      r.col = sum[PB] ? PMAX : sum[PB-1:0];
    end else if (s.col != PMAX) begin
      r.col = s.col + PONE;
    end
    return r;
  endfunction

  function automatic rec_t rtok(input st_t s, input logic [5:0] k);
    rec_t e;
    e     = '0;
    e.v   = 1'b1;
    e.ctl = '{scl_pkg::EV_TOKEN, k, scl_pkg::ERR_UNEXPECTED};
    e.fl  = s.sl;
    e.ll  = s.line;
    e.fc  = s.sc;
    e.lc  = (s.col != '0) ? s.col - PONE : '0;
    return e;
  endfunction

  function automatic rec_t rlex(input logic [CB-1:0] c);
    rec_t e;
    e     = '0;
    e.v   = 1'b1;
    e.ctl = '{scl_pkg::EV_LEX, scl_pkg::K_NONE, scl_pkg::ERR_UNEXPECTED};
    e.ch  = c;
    return e;
  endfunction

  function automatic rec_t rerr(input st_t s, input logic [2:0] code);
    rec_t e;
    e     = '0;
    e.v   = 1'b1;
    e.ctl = '{scl_pkg::EV_ERROR, scl_pkg::K_NONE, code};
    e.fl  = s.line;
    return e;
  endfunction

  function automatic pass_t do_pass(input st_t s, input logic [CB-1:0] c,
                                    input logic eot,
                                    input logic [scl_pkg::TAB_BITS-1:0] tw);
    pass_t             o;
    st_t               a;
    scl_pkg::op_rule_t op;
    logic              dig, hx, ee;
    logic [5:0]        sk;
    logic [CB-1:0]     d;
    o      = '0;
    o.s    = s;
    o.done = 1'b1;
    a      = adv(s, c, tw);
    op     = scl_pkg::op_lookup(s.held);
    dig    = !eot && is_digit(c);
    hx     = !eot && is_hex(c);
    ee     = !eot && (c == cc(8'h65) || c == cc(8'h45));
    sk     = scl_pkg::single_kind(c[7:0]);
    d      = '0;
    if (c == cc(8'h6e))      d = cc(8'h0a);
    else if (c == cc(8'h74)) d = cc(8'h09);
    else if (c == cc(8'h5c) || c == cc(8'h27) || c == cc(8'h22)) d = c;
    unique case (s.mode)
      scl_pkg::M_IDLE: begin
        if (eot) begin
          o.s.sl   = s.line;
          o.s.sc   = s.col;
          o.e0     = rtok(o.s, scl_pkg::K_END);
          o.s.line = PONE;
          o.s.col  = PONE;
        end else if (is_space(c)) begin
          o.s = a;
        end else begin
          o.s    = a;
          o.s.sl = s.line;
          o.s.sc = s.col;
          if (is_digit(c)) begin
            o.e0     = rlex(c);
            o.s.mode = (c == cc(8'h30)) ? scl_pkg::M_ZERO : scl_pkg::M_DEC;
          end else if (is_word(c)) begin
            o.e0     = rlex(c);
            o.s.mode = scl_pkg::M_WORD;
          end else if (c == cc(8'h22)) begin
            o.s.mode = scl_pkg::M_STR;
          end else if (c == cc(8'h2f)) begin
            o.s.mode = scl_pkg::M_SLASH;
          end else if (c == cc(8'h2e)) begin
            o.s.mode = scl_pkg::M_DOT;
          end else if (c < cc(8'h80) && sk != scl_pkg::K_NONE) begin
            o.e0 = rtok(o.s, sk);
          end else if (c < cc(8'h80) && scl_pkg::op_lookup(c[7:0]).hit) begin
            o.s.held = c[7:0];
            o.s.mode = scl_pkg::M_OP;
          end else begin
            o.e0 = rerr(s, scl_pkg::ERR_UNEXPECTED);
          end
        end
      end
      scl_pkg::M_WORD: begin
        if (!eot && is_word(c)) begin
          o.s  = a;
          o.e0 = rlex(c);
        end else begin
          o.e0     = rtok(s, scl_pkg::K_WORD);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_OP: begin
        if (!eot && c == cc(op.c1)) begin
          o.s      = a;
          o.e0     = rtok(a, op.k1);
          o.s.mode = scl_pkg::M_IDLE;
        end else if (!eot && op.c2 != 8'h00 && c == cc(op.c2)) begin
          o.s = a;
          if (op.k2 == scl_pkg::K_NONE) begin
            o.s.mode = scl_pkg::M_OP2;
          end else begin
            o.e0     = rtok(a, op.k2);
            o.s.mode = scl_pkg::M_IDLE;
          end
        end else begin
          o.e0     = rtok(s, op.dflt);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_OP2: begin
        if (!eot && c == cc(8'h3d)) begin
          o.s  = a;
          o.e0 = rtok(a, (s.held == 8'h3c) ? scl_pkg::K_SHL_EQ : scl_pkg::K_SHR_EQ);
        end else begin
          o.e0   = rtok(s, (s.held == 8'h3c) ? scl_pkg::K_SHL : scl_pkg::K_SHR);
          o.done = 1'b0;
        end
        o.s.mode = scl_pkg::M_IDLE;
      end
      scl_pkg::M_SLASH: begin
        if (!eot && c == cc(8'h2a)) begin
          o.s      = a;
          o.s.mode = scl_pkg::M_BLOCK;
        end else if (!eot && c == cc(8'h2f)) begin
          o.s      = a;
          o.s.mode = scl_pkg::M_LINE;
        end else if (!eot && c == cc(8'h3d)) begin
          o.s      = a;
          o.e0     = rtok(a, scl_pkg::K_DIV_EQ);
          o.s.mode = scl_pkg::M_IDLE;
        end else begin
          o.e0     = rtok(s, scl_pkg::K_DIV);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_DOT: begin
        if (dig) begin
          o.s      = a;
          o.e0     = rlex(cc(8'h2e));
          o.e1     = rlex(c);
          o.s.mode = scl_pkg::M_FRAC;
        end else begin
          o.e0     = rtok(s, scl_pkg::K_DOT);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_BLOCK, scl_pkg::M_BSTAR: begin
        if (eot) begin
          o.e0     = rerr(s, scl_pkg::ERR_COMMENT);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end else begin
          o.s = a;
          if (c == cc(8'h2a))
            o.s.mode = scl_pkg::M_BSTAR;
          else if (c == cc(8'h2f) && s.mode == scl_pkg::M_BSTAR)
            o.s.mode = scl_pkg::M_IDLE;
          else
            o.s.mode = scl_pkg::M_BLOCK;
        end
      end
      scl_pkg::M_LINE: begin
        if (eot) begin
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end else begin
          o.s = a;
          if (c == cc(8'h0a)) o.s.mode = scl_pkg::M_IDLE;
        end
      end
      scl_pkg::M_ZERO: begin
        if (!eot && c == cc(8'h78)) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_HEX0;
        end else if (!eot && c == cc(8'h2e)) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_FRAC;
        end else if (dig) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_ZDIG;
        end else begin
          o.e0     = rtok(s, scl_pkg::K_INT);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_HEX0, scl_pkg::M_HEX: begin
        if (hx) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_HEX;
        end else begin
          o.e0     = (s.mode == scl_pkg::M_HEX) ? rtok(s, scl_pkg::K_HEX)
                                                : rerr(s, scl_pkg::ERR_NUMBER);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_DEC, scl_pkg::M_ZDIG: begin
        if (dig) begin
          o.s  = a;
          o.e0 = rlex(c);
        end else if (!eot && c == cc(8'h2e)) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_FRAC;
        end else if (ee) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_EXP;
        end else begin
          o.e0     = (s.mode == scl_pkg::M_DEC) ? rtok(s, scl_pkg::K_INT)
                                                : rerr(s, scl_pkg::ERR_NUMBER);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_FRAC, scl_pkg::M_EDIG: begin
        if (dig) begin
          o.s  = a;
          o.e0 = rlex(c);
        end else if (ee && s.mode == scl_pkg::M_FRAC) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_EXP;
        end else if (!eot && (c == cc(8'h66) || c == cc(8'h46))) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.e1     = rtok(a, scl_pkg::K_FLOAT);
          o.s.mode = scl_pkg::M_IDLE;
        end else begin
          o.e0     = rtok(s, scl_pkg::K_FLOAT);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_EXP, scl_pkg::M_ESIGN: begin
        if (s.mode == scl_pkg::M_EXP && !eot &&
            (c == cc(8'h2b) || c == cc(8'h2d))) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_ESIGN;
        end else if (dig) begin
          o.s      = a;
          o.e0     = rlex(c);
          o.s.mode = scl_pkg::M_EDIG;
        end else begin
          o.e0     = rerr(s, scl_pkg::ERR_NUMBER);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_STR: begin
        if (eot) begin
          o.e0     = rerr(s, scl_pkg::ERR_QUOTE);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end else begin
          o.s = a;
          if (c == cc(8'h22)) begin
            o.e0     = rtok(a, scl_pkg::K_STRING);
            o.s.mode = scl_pkg::M_IDLE;
          end else if (c == cc(8'h5c)) begin
            o.s.mode = scl_pkg::M_ESC;
          end else if (c == cc(8'h0a)) begin
            o.e0     = rerr(a, scl_pkg::ERR_QUOTE);
            o.s.mode = scl_pkg::M_IDLE;
          end else begin
            o.e0 = rlex(c);
          end
        end
      end
      scl_pkg::M_ESC: begin
        if (!eot && d != '0) begin
          o.s      = a;
          o.e0     = rlex(d);
          o.s.mode = scl_pkg::M_STR;
        end else if (!eot && c == cc(8'h78)) begin
          o.s      = a;
          o.s.mode = scl_pkg::M_XESC0;
        end else begin
          o.e0     = rerr(s, scl_pkg::ERR_ESCAPE);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_XESC0: begin
        if (hx) begin
          o.s      = a;
          o.s.esc  = CB'(hex_val(c));
          o.s.mode = scl_pkg::M_XESC;
        end else begin
          o.e0     = rerr(s, scl_pkg::ERR_ESCAPE);
          o.s.mode = scl_pkg::M_IDLE;
          o.done   = 1'b0;
        end
      end
      scl_pkg::M_XESC: begin
        if (hx) begin
          o.s     = a;
          o.s.esc = {s.esc[CB-5:0], hex_val(c)};
        end else begin
          o.e0     = rlex(s.esc);
          o.s.mode = scl_pkg::M_STR;
          o.done   = 1'b0;
        end
      end
      default: begin
        o.s.mode = scl_pkg::M_IDLE;
        o.done   = 1'b0;
      end
    endcase
    return o;
  endfunction

  always_comb begin
    pass_t      p;
    st_t        s;
    logic       done;
    logic       eot;
    rec_t       cand [2*scl_pkg::MAX_RESULTS];
    rec_t       slot [scl_pkg::MAX_RESULTS];
    logic [2:0] n;
    p    = '0;
    s    = st_r;
    done = 1'b0;
    eot  = end_of_text || (char_code == '0);
    for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) begin
      cand[2*i]   = '0;
      cand[2*i+1] = '0;
      if (!done) begin
        p           = do_pass(s, char_code, eot, tab_width);
        s           = p.s;
        done        = p.done;
        cand[2*i]   = p.e0;
        cand[2*i+1] = p.e1;
      end
    end
    st_nxt = s;
    n = '0;
    for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) slot[i] = '0;
    for (int i = 0; i < 2*scl_pkg::MAX_RESULTS; i++) begin
      if (cand[i].v && n < 3'(scl_pkg::MAX_RESULTS)) begin
        slot[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    res_cnt = n;
    for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) begin
      res_ctl[i] = slot[i].ctl;
      res_ch[i]  = slot[i].ch;
      res_fl[i]  = slot[i].fl;
      res_ll[i]  = slot[i].ll;
      res_fc[i]  = slot[i].fc;
      res_lc[i]  = slot[i].lc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= scl_pkg::M_IDLE;
      st_r.line <= PONE;
      st_r.col  <= PONE;
      st_r.sl   <= '0;
      st_r.sc   <= '0;
      st_r.held <= '0;
      st_r.esc  <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/scl_out_buf.sv
// ----------------------------------------------------------------------------
// scl_out_buf - tokenizer result buffer
// Holds the events of one character and hands them out one per transaction.
// ----------------------------------------------------------------------------
module scl_out_buf #(
  parameter int CHAR_BITS     = scl_pkg::CHAR_BITS_DEF,
  parameter int POSITION_BITS = scl_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  scl_pkg::ev_ctrl_t        res_ctl [scl_pkg::MAX_RESULTS],
  input  logic [CHAR_BITS-1:0]     res_ch  [scl_pkg::MAX_RESULTS],
  input  logic [POSITION_BITS-1:0] res_fl  [scl_pkg::MAX_RESULTS],
  input  logic [POSITION_BITS-1:0] res_ll  [scl_pkg::MAX_RESULTS],
  input  logic [POSITION_BITS-1:0] res_fc  [scl_pkg::MAX_RESULTS],
  input  logic [POSITION_BITS-1:0] res_lc  [scl_pkg::MAX_RESULTS],
  input  logic [2:0]               res_cnt,
  output logic                     load_ok,
  scl_out_if.source                out_ch
);

  scl_pkg::ev_ctrl_t        ctl_r [scl_pkg::MAX_RESULTS];
  logic [CHAR_BITS-1:0]     ch_r  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0] fl_r  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0] ll_r  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0] fc_r  [scl_pkg::MAX_RESULTS];
  logic [POSITION_BITS-1:0] lc_r  [scl_pkg::MAX_RESULTS];
  logic [2:0]               cnt_r;
  logic [1:0]               pos_r;
  logic                     take;

  assign take    = out_ch.valid && out_ch.ready;
  assign load_ok = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);

  assign out_ch.valid       = (cnt_r != 3'd0);
  assign out_ch.event_kind  = ctl_r[pos_r].event_kind;
  assign out_ch.token_kind  = ctl_r[pos_r].token_kind;
  assign out_ch.error_code  = ctl_r[pos_r].error_code;
  assign out_ch.lexeme_char = ch_r[pos_r];
  assign out_ch.first_line  = fl_r[pos_r];
  assign out_ch.last_line   = ll_r[pos_r];
  assign out_ch.first_col   = fc_r[pos_r];
  assign out_ch.last_col    = lc_r[pos_r];
  assign out_ch.last_of_run = (cnt_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (load) begin
      cnt_r <= res_cnt;
      pos_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r <= res_ctl;
      ch_r  <= res_ch;
      fl_r  <= res_fl;
      ll_r  <= res_ll;
      fc_r  <= res_fc;
      lc_r  <= res_lc;
    end
  end

endmodule

// File: verif/tb_source_code_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_source_code_tokenizer - tokenizer testbench
// Drives character transactions with random bursts and gaps, stalls the event
// channel on its own pattern, and checks every event against a local lexer
// model kept in a scoreboard class. tab_width is changed between phases.
// ----------------------------------------------------------------------------
module tb_source_code_tokenizer;
  import scl_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] lexeme_char;
    logic [15:0] first_line;
    logic [15:0] last_line;
    logic [15:0] first_col;
    logic [15:0] last_col;
    logic        last_of_run;
  } lex_event_t;

  typedef enum int {
    S_IDLE, S_WORD, S_OP, S_OP2, S_SLASH, S_DOT, S_BLOCK, S_BSTAR, S_LINE,
    S_ZERO, S_HEX0, S_HEX, S_DEC, S_ZDIG, S_FRAC, S_EXP, S_ESIGN, S_EDIG,
    S_STR, S_ESC, S_XESC0, S_XESC
  } lex_state_t;

  class lexer_scoreboard;
    lex_state_t st;
    logic [15:0] line_no, col_no, tok_line, tok_col, held, esc_val;
    logic [4:0] tab_w;
    lex_event_t pending[$];
    lex_event_t step_evs[$];
    int errors;

    function new();
      errors = 0;
      reset();
    endfunction

    function void reset();
      st = S_IDLE; line_no = 1; col_no = 1; tok_line = 0; tok_col = 0;
      held = 0; esc_val = 0; tab_w = TAB_WIDTH_RST;
    endfunction

    function bit is_space(logic [15:0] c);
      return c == 16'h20 || (c >= 16'h09 && c <= 16'h0d);
    endfunction
    function bit is_dig(logic [15:0] c);
      return c >= 16'h30 && c <= 16'h39;
    endfunction
    function bit is_hexd(logic [15:0] c);
      return is_dig(c) || (c >= 16'h41 && c <= 16'h46) || (c >= 16'h61 && c <= 16'h66);
    endfunction
    function logic [15:0] hex_of(logic [15:0] c);
      if (is_dig(c)) return c - 16'h30;
      if (c >= 16'h61) return c - 16'h61 + 10;
      return c - 16'h41 + 10;
    endfunction
    function bit is_punct(logic [15:0] c);
      return (c >= 16'h21 && c <= 16'h2f) || (c >= 16'h3a && c <= 16'h40) ||
             (c >= 16'h5b && c <= 16'h5e) || (c >= 16'h7b && c <= 16'h7e);
    endfunction
    function bit is_wordc(logic [15:0] c);
      return (c >= 16'h21 && c <= 16'h7e && !is_punct(c)) || c >= 16'h80;
    endfunction
    function logic [5:0] one_char_kind(logic [15:0] c);
      case (c)
        "(": return 6'd13; ")": return 6'd14; ",": return 6'd20;
        ":": return 6'd27; ";": return 6'd28; "?": return 6'd39;
        "[": return 6'd40; "]": return 6'd41; "{": return 6'd44;
        "}": return 6'd48; "~": return 6'd49;
        default: return K_NONE;
      endcase
    endfunction
    // returns lead-valid, c1, k1, c2, k2, default
    function bit op_rule(logic [15:0] c, output logic [7:0] c1, output logic [5:0] k1,
                         output logic [7:0] c2, output logic [5:0] k2,
                         output logic [5:0] kd);
      c1 = "="; c2 = 0; k2 = 0;
      case (c)
        "!": begin k1 = 6; kd = 7; end
        "%": begin k1 = 8; kd = 9; end
        "&": begin k1 = 10; c2 = "&"; k2 = 11; kd = 12; end
        "*": begin k1 = 15; kd = 16; end
        "+": begin k1 = 17; c2 = "+"; k2 = 18; kd = 19; end
        "-": begin k1 = 21; c2 = "-"; k2 = 22; kd = 23; end
        "<": begin k1 = 31; c2 = "<"; kd = 32; end
        "=": begin k1 = 33; kd = 34; end
        ">": begin k1 = 37; c2 = ">"; kd = 38; end
        "^": begin k1 = 42; kd = 43; end
        "|": begin k1 = 45; c2 = "|"; k2 = 46; kd = 47; end
        default: begin k1 = 0; kd = 0; return 0; end
      endcase
      return 1;
    endfunction

    function void push(logic [1:0] ev, logic [5:0] tk, logic [2:0] er, logic [15:0] ch,
                       logic [15:0] fl, logic [15:0] ll, logic [15:0] fc,
                       logic [15:0] lc);
      lex_event_t e;
      e = '{ev, tk, er, ch, fl, ll, fc, lc, 1'b0};
      if (step_evs.size() < MAX_RESULTS) step_evs = {step_evs, e};
    endfunction

    function void advance(logic [15:0] c);
      int n;
      if (c == 16'h0a) begin
        if (line_no != 16'hffff) line_no++;
        col_no = 1;
      end else if (c == 16'h09) begin
        n = col_no + tab_w;
        col_no = n > 65535 ? 16'hffff : n[15:0];
      end else if (col_no != 16'hffff) begin
        col_no++;
      end
    endfunction

    function void lexc(logic [15:0] c); push(EV_LEX, 0, 0, c, 0, 0, 0, 0); endfunction
    function void take(logic [15:0] c); advance(c); lexc(c); endfunction
    function void fault(logic [2:0] code);
      push(EV_ERROR, 0, code, 0, line_no, 0, 0, 0);
      st = S_IDLE;
    endfunction
    function void done(logic [5:0] k);
      push(EV_TOKEN, k, 0, 0, tok_line, line_no, tok_col, col_no == 0 ? 16'd0 : col_no - 1);
      st = S_IDLE;
    endfunction
    function void mark(); tok_line = line_no; tok_col = col_no; endfunction

    // 1 when the character is consumed, 0 when it is offered again
    function bit scan(logic [15:0] c, bit eot);
      bit dig, hx, ok;
      logic [7:0] c1, c2;
      logic [5:0] k1, k2, kd, sk;
      logic [15:0] d;
      dig = !eot && is_dig(c);
      hx = !eot && is_hexd(c);
      case (st)
        S_IDLE: begin
          if (eot) begin
            mark(); done(K_END); line_no = 1; col_no = 1; return 1;
          end
          if (is_space(c)) begin advance(c); return 1; end
          mark();
          if (is_dig(c)) begin take(c); st = (c == 16'h30) ? S_ZERO : S_DEC; return 1; end
          if (is_wordc(c)) begin take(c); st = S_WORD; return 1; end
          if (c == "\"") begin advance(c); st = S_STR; return 1; end
          if (c == "/") begin advance(c); st = S_SLASH; return 1; end
          if (c == ".") begin advance(c); st = S_DOT; return 1; end
          sk = one_char_kind(c);
          if (sk != K_NONE) begin advance(c); done(sk); return 1; end
          if (op_rule(c, c1, k1, c2, k2, kd)) begin
            advance(c); held = c; st = S_OP; return 1;
          end
          fault(ERR_UNEXPECTED); advance(c); return 1;
        end
        S_WORD: begin
          if (!eot && is_wordc(c)) begin take(c); return 1; end
          done(K_WORD); return 0;
        end
        S_OP: begin
          ok = op_rule(held, c1, k1, c2, k2, kd);
          if (!ok) begin st = S_IDLE; return 0; end
          if (!eot && c == c1) begin advance(c); done(k1); return 1; end
          if (!eot && c2 != 0 && c == c2) begin
            advance(c);
            if (k2 == 0) st = S_OP2; else done(k2);
            return 1;
          end
          done(kd); return 0;
        end
        S_OP2: begin
          if (!eot && c == "=") begin
            advance(c); done(held == "<" ? K_SHL_EQ : K_SHR_EQ); return 1;
          end
          done(held == "<" ? K_SHL : K_SHR); return 0;
        end
        S_SLASH: begin
          if (!eot && c == "*") begin advance(c); st = S_BLOCK; return 1; end
          if (!eot && c == "/") begin advance(c); st = S_LINE; return 1; end
          if (!eot && c == "=") begin advance(c); done(K_DIV_EQ); return 1; end
          done(K_DIV); return 0;
        end
        S_DOT: begin
          if (dig) begin lexc("."); take(c); st = S_FRAC; return 1; end
          done(K_DOT); return 0;
        end
        S_BLOCK, S_BSTAR: begin
          if (eot) begin fault(ERR_COMMENT); return 0; end
          advance(c);
          if (c == "*") st = S_BSTAR;
          else if (c == "/" && st == S_BSTAR) st = S_IDLE;
          else st = S_BLOCK;
          return 1;
        end
        S_LINE: begin
          if (eot) begin st = S_IDLE; return 0; end
          advance(c);
          if (c == 16'h0a) st = S_IDLE;
          return 1;
        end
        S_ZERO: begin
          if (!eot && c == "x") begin take(c); st = S_HEX0; return 1; end
          if (!eot && c == ".") begin take(c); st = S_FRAC; return 1; end
          if (dig) begin take(c); st = S_ZDIG; return 1; end
          done(K_INT); return 0;
        end
        S_HEX0: begin
          if (hx) begin take(c); st = S_HEX; return 1; end
          fault(ERR_NUMBER); return 0;
        end
        S_HEX: begin
          if (hx) begin take(c); return 1; end
          done(K_HEX); return 0;
        end
        S_DEC, S_ZDIG: begin
          if (dig) begin take(c); return 1; end
          if (!eot && c == ".") begin take(c); st = S_FRAC; return 1; end
          if (!eot && (c == "e" || c == "E")) begin take(c); st = S_EXP; return 1; end
          if (st == S_DEC) done(K_INT); else fault(ERR_NUMBER);
          return 0;
        end
        S_FRAC, S_EDIG: begin
          if (dig) begin take(c); return 1; end
          if (!eot && (c == "e" || c == "E") && st == S_FRAC) begin
            take(c); st = S_EXP; return 1;
          end
          if (!eot && (c == "f" || c == "F")) begin take(c); done(K_FLOAT); return 1; end
          done(K_FLOAT); return 0;
        end
        S_EXP: begin
          if (!eot && (c == "+" || c == "-")) begin take(c); st = S_ESIGN; return 1; end
          if (dig) begin take(c); st = S_EDIG; return 1; end
          fault(ERR_NUMBER); return 0;
        end
        S_ESIGN: begin
          if (dig) begin take(c); st = S_EDIG; return 1; end
          fault(ERR_NUMBER); return 0;
        end
        S_STR: begin
          if (eot) begin fault(ERR_QUOTE); return 0; end
          if (c == "\"") begin advance(c); done(K_STRING); return 1; end
          if (c == 16'h5c) begin advance(c); st = S_ESC; return 1; end
          if (c == 16'h0a) begin advance(c); fault(ERR_QUOTE); return 1; end
          take(c); return 1;
        end
        S_ESC: begin
          if (!eot) begin
            d = 0;
            if (c == "n") d = 16'h0a;
            else if (c == "t") d = 16'h09;
            else if (c == 16'h5c || c == 16'h27 || c == 16'h22) d = c;
            if (d != 0) begin advance(c); lexc(d); st = S_STR; return 1; end
            if (c == "x") begin advance(c); st = S_XESC0; return 1; end
          end
          fault(ERR_ESCAPE); return 0;
        end
        S_XESC0: begin
          if (hx) begin advance(c); esc_val = hex_of(c); st = S_XESC; return 1; end
          fault(ERR_ESCAPE); return 0;
        end
        S_XESC: begin
          if (hx) begin advance(c); esc_val = {esc_val[11:0], 4'h0} | hex_of(c); return 1; end
          lexc(esc_val); st = S_STR; return 0;
        end
        default: begin st = S_IDLE; return 0; end
      endcase
    endfunction

    function void note_char(logic [15:0] c, logic eot_in);
      bit eot;
      eot = eot_in || c == 0;
      step_evs.delete();
      for (int g = 0; g < 6; g++)
        if (scan(c, eot)) break;
      if (step_evs.size() > 0) step_evs[step_evs.size()-1].last_of_run = 1'b1;
      pending = {pending, step_evs};
    endfunction

    function void check_event(lex_event_t got);
      lex_event_t exp_ev;
      if (pending.size() == 0) begin
        $error("unexpected event %p", got);
        errors++;
        return;
      end
      exp_ev = pending.pop_front();
      if (got.event_kind !== exp_ev.event_kind) begin
        $error("event_kind exp %0d got %0d", exp_ev.event_kind, got.event_kind); errors++;
      end
      if (got.token_kind !== exp_ev.token_kind) begin
        $error("token_kind exp %0d got %0d", exp_ev.token_kind, got.token_kind); errors++;
      end
      if (got.error_code !== exp_ev.error_code) begin
        $error("error_code exp %0d got %0d", exp_ev.error_code, got.error_code); errors++;
      end
      if (got.lexeme_char !== exp_ev.lexeme_char) begin
        $error("lexeme_char exp %h got %h", exp_ev.lexeme_char, got.lexeme_char); errors++;
      end
      if (got.first_line !== exp_ev.first_line) begin
        $error("first_line exp %0d got %0d", exp_ev.first_line, got.first_line); errors++;
      end
      if (got.last_line !== exp_ev.last_line) begin
        $error("last_line exp %0d got %0d", exp_ev.last_line, got.last_line); errors++;
      end
      if (got.first_col !== exp_ev.first_col) begin
        $error("first_col exp %0d got %0d", exp_ev.first_col, got.first_col); errors++;
      end
      if (got.last_col !== exp_ev.last_col) begin
        $error("last_col exp %0d got %0d", exp_ev.last_col, got.last_col); errors++;
      end
      if (got.last_of_run !== exp_ev.last_of_run) begin
        $error("last_of_run exp %0d got %0d", exp_ev.last_of_run, got.last_of_run); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we;
  logic [TAB_BITS-1:0] cfg_wdata;
  int idle_cycles;
  bit stall_mode;

  scl_in_if  in_ch ();
  scl_out_if out_ch ();

  source_code_tokenizer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lexer_scoreboard sb = new();

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_char(in_ch.char_code, in_ch.end_of_text);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_event('{out_ch.event_kind, out_ch.token_kind, out_ch.error_code,
                       out_ch.lexeme_char, out_ch.first_line, out_ch.last_line,
                       out_ch.first_col, out_ch.last_col, out_ch.last_of_run});
  end

  // receiver stall pattern: long open stretches alternate with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      out_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  int burst_left;

  task automatic send_char(input logic [15:0] c, input logic eot);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(16'(s[i]), 1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tab(input logic [4:0] w);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tab_w = w;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_char();
    string pool;
    pool = "abzAZ_09x.eEfF+-*/=<>!%&|^~()[]{};:,?\"\\ \t\n#$@'ntx";
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(16'h80, 16'hffff));
      2: return 16'($urandom_range(1, 16'h1f));
      default: return 16'(pool[$urandom_range(0, pool.len() - 1)]);
    endcase
  endfunction

  task automatic send_random_fragment();
    string frags[$];
    frags = '{"abc ", "0x1F ", "0xg", "12.5e+3f ", "1e-", "09.5 ", "07;", ".5 ", "0. ",
              "\"a\\n\\t\\\\\\'\\\"\\x41z\" ", "\"bad\\q\" ", "\"x\\xffff1\"", "/*c*/",
              "// c\n", "a<<=b>>c>>=d<=e>=f", "x&&y||z&=1|=2", "i++ --j += -= ",
              "a!=b%=c*=d^=e==f", "\"open\n", "/=/", "1.2e5", "0x", "3ee"};
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) send_char(rand_char(), 1'b0);
    end else begin
      send_text(frags[$urandom_range(0, frags.size() - 1)]);
      repeat ($urandom_range(0, 3)) send_char(rand_char(), 1'b0);
    end
  endtask

  initial begin
    int sent;
    rst_n = 0; cfg_we = 0; cfg_wdata = 0;
    in_ch.valid = 0; in_ch.char_code = 0; in_ch.end_of_text = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sb.reset();

    // directed: punctuators, numbers, strings, comments, special cases
    send_text("a1 0x9f 0. .7 1e+2f \"q\\x41\"\t");
    send_char(16'hffff, 1'b0);
    send_char(16'h0000, 1'b0);
    send_text("<<= >> ~ # /* open");
    send_char(16'h0041, 1'b1);
    send_text("// tail");
    send_char(16'h0, 1'b1);
    drain();

    set_tab(5'd0);
    send_text("\t\tx\t;");
    send_char(0, 1'b1);
    drain();
    set_tab(5'd31);
    send_text("\t\"s\ns\" 08 0xq 5e \"\\z\" \"ab");
    send_char(0, 1'b1);
    drain();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_tab(5'd1);
        1: set_tab(5'd16);
        2: set_tab(5'($urandom_range(0, 31)));
        default: set_tab(TAB_WIDTH_RST);
      endcase
      repeat (10) begin
        send_random_fragment();
        if ($urandom_range(0, 7) == 0) send_char(16'($urandom_range(0, 65535)), 1'b1);
      end
      send_char(0, 1'b1);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending.size() != 0) $error("%0d events never arrived", sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/scl_pkg.sv
rtl/scl_in_if.sv
rtl/scl_out_if.sv
rtl/scl_core.sv
rtl/scl_out_buf.sv
rtl/source_code_tokenizer.sv
verif/tb_source_code_tokenizer.sv
